// ===== rtl/pwm_audio_sample_queue_core_macros.svh =====
// Assertion helpers shared by the sample queue RTL.
`ifndef PWM_AUDIO_SAMPLE_QUEUE_CORE_MACROS_SVH
`define PWM_AUDIO_SAMPLE_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PASQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PASQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pasq_pkg.sv =====
`default_nettype none
package pasq_pkg;

  // Queue geometry: depth is a power of two, count holds the depth itself
  localparam int unsigned Q_AW    = 10;
  localparam int unsigned Q_DEPTH = 1 << Q_AW;
  localparam int unsigned Q_CW    = Q_AW + 1;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned THR_W   = 11;

  // Command codes of an input item
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PULL  = 1'b1
  } pasq_cmd_t;

  // Configuration register indexes
  typedef enum logic {
    REG_RANGE_MAX      = 1'b0,
    REG_NEED_THRESHOLD = 1'b1
  } pasq_reg_t;

  // Where the result level comes from
  typedef enum logic [1:0] {
    SRC_PRE   = 2'd0,
    SRC_STORE = 2'd1
  } pasq_src_t;

  // Status fields carried with one result
  typedef struct packed {
    logic            accepted;
    logic            padded;
    logic            need_data;
    logic [Q_CW-1:0] frames_held;
  } pasq_status_t;

endpackage
`default_nettype wire

// ===== rtl/pwm_audio_sample_queue_core.sv =====
`default_nettype none
// A result passes the stage registers, then the result register (memory read is registered).
// One item per cycle while results are taken; a held result stalls input after one.
// The level store is a 1024 x 16 synchronous RAM with one write and one read port.
// Reset (rst_n low, synchronous) empties the queue and loads range_max 5668, need_threshold 512.
// Store contents are not cleared; the fill count guards every read, so no clearing pass runs.
module pwm_audio_sample_queue_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic signed [15:0]            in_sample,
  input  wire logic                          in_chunk_end,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pasq_pkg::LEVEL_W-1:0]       out_level,
  output logic                               out_accepted,
  output logic                               out_padded,
  output logic                               out_need_data,
  output logic [pasq_pkg::Q_CW-1:0]          out_frames_held,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import pasq_pkg::*;

  `include "pwm_audio_sample_queue_core_macros.svh"

  // configuration
  logic [LEVEL_W-1:0] range_max_r;
  logic [THR_W-1:0]   need_thr_r;

  // queue control
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] fill_r, fill_nxt;

  // stage between transfer and result
  logic               busy_r, busy_nxt;
  pasq_src_t          src_r;
  logic [LEVEL_W-1:0] pre_level_r;
  pasq_status_t       st_r;
  logic [LEVEL_W-1:0] rd_data_r;

  // result register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  pasq_status_t       out_st_r;

  // level store
  logic [LEVEL_W-1:0] level_mem [Q_DEPTH];

  logic                   in_xfer;
  logic                   complete;
  logic                   is_pull;
  logic                   q_full;
  logic                   q_empty;
  logic                   do_store;
  logic                   do_fetch;
  logic [LEVEL_W-1:0]     offset;
  logic [2*LEVEL_W-1:0]   product;
  logic [LEVEL_W-1:0]     scaled;
  logic [LEVEL_W-1:0]     idle_level;
  pasq_status_t           st_nxt;
  logic [Q_AW-1:0]        ptr_gap;

  assign cfg_ready = 1'b1;

  // handshake: the stage drains into the result register when it is free or taken
  assign complete = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r && !complete;
  assign in_xfer  = in_valid && !in_stall;

  assign is_pull  = (pasq_cmd_t'(in_command) == CMD_PULL);
  assign q_full   = (fill_r == Q_CW'(Q_DEPTH));
  assign q_empty  = (fill_r == '0);
  assign do_store = in_xfer && !is_pull && !q_full;
  assign do_fetch = in_xfer && is_pull && !q_empty;

  // scale: (s + 32768) * range_max >> 16
  assign offset     = {~in_sample[15], in_sample[14:0]};
  assign product    = offset * range_max_r;
  assign scaled     = product[2*LEVEL_W-1:LEVEL_W];
  assign idle_level = {1'b0, range_max_r[LEVEL_W-1:1]};

  // next queue state and result status
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    busy_nxt   = busy_r;
    if (do_store) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end
    if (do_fetch) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
    end
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end else if (complete) begin
      busy_nxt = 1'b0;
    end
    st_nxt.accepted    = is_pull || !q_full;
    st_nxt.padded      = is_pull && q_empty;
    st_nxt.need_data   = is_pull && in_chunk_end && (fill_nxt < need_thr_r);
    st_nxt.frames_held = fill_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_max_r <= LEVEL_W'(5668);
      need_thr_r  <= THR_W'(512);
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pasq_reg_t'(cfg_index))
          REG_RANGE_MAX:      range_max_r <= cfg_data;
          REG_NEED_THRESHOLD: need_thr_r  <= cfg_data[THR_W-1:0];
          default:            ;
        endcase
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      busy_r   <= busy_nxt;
      if (complete) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture the item's stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      src_r       <= do_fetch ? SRC_STORE : SRC_PRE;
      pre_level_r <= is_pull ? idle_level : scaled;
      st_r        <= st_nxt;
    end
  end

  // level store: write on accepted sample, registered read on pull
  always_ff @(posedge clk) begin
    if (do_store) begin
      level_mem[wr_ptr_r] <= scaled;
    end
    if (do_fetch) begin
      rd_data_r <= level_mem[rd_ptr_r];
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (complete) begin
      out_level_r <= (src_r == SRC_STORE) ? rd_data_r : pre_level_r;
      out_st_r    <= st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_accepted    = out_st_r.accepted;
  assign out_padded      = out_st_r.padded;
  assign out_need_data   = out_st_r.need_data;
  assign out_frames_held = out_st_r.frames_held;

  assign ptr_gap = wr_ptr_r - rd_ptr_r;

  `PASQ_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= Q_CW'(Q_DEPTH), "fill above depth")
  `PASQ_ASSERT_IMPLY(a_ptr_gap, clk, rst_n, 1'b1, ptr_gap == fill_r[Q_AW-1:0], "pointers disagree with fill")
  `PASQ_ASSERT_NEXT(a_xfer_busy, clk, rst_n, in_xfer, busy_r, "transfer did not enter stage")
  `PASQ_ASSERT_IMPLY(a_pad_empty, clk, rst_n, out_valid_r && out_st_r.padded, out_st_r.frames_held == '0, "padded result with frames held")

endmodule
`default_nettype wire

// ===== tb/sv/pwm_audio_sample_queue_core_tb.sv =====
`default_nettype none
module pwm_audio_sample_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pasq_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned SETTLE_WAIT  = 6;

  // One result: PWM level plus the status fields
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    pasq_status_t       status;
  } pwm_frame_t;

  typedef struct {
    pasq_cmd_t   cmd;
    logic [15:0] sample;
    logic        chunk_end;
    bit          typed;
    pwm_frame_t  want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_command;
  logic signed [15:0]  in_sample;
  logic                in_chunk_end;
  logic                out_valid;
  logic                out_stall;
  logic [LEVEL_W-1:0]  out_level;
  logic                out_accepted;
  logic                out_padded;
  logic                out_need_data;
  logic [Q_CW-1:0]     out_frames_held;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [15:0]         cfg_data;

  // Frame queue mirror and register copies
  logic [LEVEL_W-1:0]  level_ring [Q_DEPTH];
  int unsigned         ring_head = 0;
  int unsigned         ring_tail = 0;
  int unsigned         ring_fill = 0;
  logic [LEVEL_W-1:0]  pwm_range = 16'd5668;
  logic [THR_W-1:0]    refill_mark = 11'd512;

  pwm_frame_t          frames_due [$];
  int unsigned         mismatches = 0;
  int unsigned         sender_idle_pct;
  int unsigned         recv_idle_pct;
  bit                  hold_off_req;

  // Short directed run at the reset settings (range 5668, threshold 512)
  stim_row_t directed_rows [17] = '{
    '{CMD_PULL,  16'h0000, 1'b1, 1'b1, {16'd2834, 1'b1, 1'b1, 1'b1, 11'd0}},
    '{CMD_PULL,  16'h0000, 1'b0, 1'b1, {16'd2834, 1'b1, 1'b1, 1'b0, 11'd0}},
    '{CMD_WRITE, 16'h8000, 1'b0, 1'b1, {16'd0,    1'b1, 1'b0, 1'b0, 11'd1}},
    '{CMD_WRITE, 16'h7fff, 1'b1, 1'b1, {16'd5667, 1'b1, 1'b0, 1'b0, 11'd2}},
    '{CMD_WRITE, 16'h0000, 1'b0, 1'b1, {16'd2834, 1'b1, 1'b0, 1'b0, 11'd3}},
    '{CMD_WRITE, 16'hffff, 1'b0, 1'b1, {16'd2833, 1'b1, 1'b0, 1'b0, 11'd4}},
    '{CMD_WRITE, 16'h0001, 1'b0, 1'b1, {16'd2834, 1'b1, 1'b0, 1'b0, 11'd5}},
    '{CMD_PULL,  16'h0000, 1'b0, 1'b1, {16'd0,    1'b1, 1'b0, 1'b0, 11'd4}},
    '{CMD_PULL,  16'hffff, 1'b1, 1'b1, {16'd5667, 1'b1, 1'b0, 1'b1, 11'd3}},
    '{CMD_WRITE, 16'h5555, 1'b0, 1'b0, '0},
    '{CMD_WRITE, 16'haaaa, 1'b1, 1'b0, '0},
    '{CMD_PULL,  16'h1234, 1'b1, 1'b0, '0},
    '{CMD_PULL,  16'h0000, 1'b0, 1'b0, '0},
    '{CMD_PULL,  16'h0000, 1'b0, 1'b0, '0},
    '{CMD_PULL,  16'h0000, 1'b1, 1'b0, '0},
    '{CMD_PULL,  16'h0000, 1'b1, 1'b0, '0},
    '{CMD_WRITE, 16'h1234, 1'b1, 1'b0, '0}
  };

  pwm_audio_sample_queue_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_sample       (in_sample),
    .in_chunk_end    (in_chunk_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_accepted    (out_accepted),
    .out_padded      (out_padded),
    .out_need_data   (out_need_data),
    .out_frames_held (out_frames_held),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the queue mirror by one item and return the frame it yields
  function automatic pwm_frame_t pwm_queue_step(pasq_cmd_t cmd, logic [15:0] smp, logic ce);
    pwm_frame_t  res;
    logic [31:0] prod;
    res = '0;
    res.status.accepted = 1'b1;
    if (cmd == CMD_WRITE) begin
      // offset binary: flip the sign bit, then scale by the range
      prod = {16'd0, ~smp[15], smp[14:0]} * {16'd0, pwm_range};
      res.level = prod[31:16];
      if (ring_fill >= Q_DEPTH) begin
        res.status.accepted = 1'b0;
      end else begin
        level_ring[ring_tail] = res.level;
        ring_tail = (ring_tail + 1) % Q_DEPTH;
        ring_fill++;
      end
    end else begin
      if (ring_fill == 0) begin
        res.level = pwm_range >> 1;
        res.status.padded = 1'b1;
      end else begin
        res.level = level_ring[ring_head];
        ring_head = (ring_head + 1) % Q_DEPTH;
        ring_fill--;
      end
      res.status.need_data = ce && (ring_fill < refill_mark);
    end
    res.status.frames_held = Q_CW'(ring_fill);
    return res;
  endfunction

  // Mostly random samples, with the extremes mixed in
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Offer one item, hold it until the transfer, then queue its expected frame
  task automatic transfer_item(pasq_cmd_t cmd, logic [15:0] smp, logic ce, bit typed,
                               pwm_frame_t want);
    pwm_frame_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_sample    <= smp;
    in_chunk_end <= ce;
    do @(posedge clk); while (in_stall);
    predicted = pwm_queue_step(cmd, smp, ce);
    frames_due.push_back(typed ? want : predicted);
  endtask

  task automatic write_register(pasq_reg_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RANGE_MAX) pwm_range = data;
    else refill_mark = data[THR_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] range_max, logic [THR_W-1:0] threshold);
    write_register(REG_RANGE_MAX, range_max);
    write_register(REG_NEED_THRESHOLD, {5'd0, threshold});
  endtask

  // Drop valid, wait for every pending frame, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Segments of write-heavy, balanced and pull-heavy traffic so the fill wanders
  task automatic run_mixed(int unsigned count);
    int unsigned left;
    int unsigned seg;
    int unsigned write_pct;
    pasq_cmd_t   cmd;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0:       write_pct = 15;
        1:       write_pct = 50;
        default: write_pct = 85;
      endcase
      while (seg > 0 && left > 0) begin
        cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_PULL;
        transfer_item(cmd, pick_sample(), 1'($urandom_range(0, 3) == 0), 1'b0, '0);
        seg--;
        left--;
      end
    end
  endtask

  // Result side: random stall, or one long hold-off on request
  initial begin : result_receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest pending frame
  always @(posedge clk) begin : result_check
    pwm_frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual level %0d", $time, out_level);
      end else begin
        want = frames_due.pop_front();
        check_field("level", want.level, out_level);
        check_field("accepted", 16'(want.status.accepted), 16'(out_accepted));
        check_field("padded", 16'(want.status.padded), 16'(out_padded));
        check_field("need_data", 16'(want.status.need_data), 16'(out_need_data));
        check_field("frames_held", 16'(want.status.frames_held), 16'(out_frames_held));
      end
    end
  end

  // End the run when no transfer of any kind happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_WRITE;
    in_sample       = '0;
    in_chunk_end    = 1'b0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_RANGE_MAX;
    cfg_data        = '0;
    hold_off_req    = 1'b0;
    sender_idle_pct = 10;
    recv_idle_pct   = 86;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset settings
    foreach (directed_rows[i])
      transfer_item(directed_rows[i].cmd, directed_rows[i].sample,
                    directed_rows[i].chunk_end, directed_rows[i].typed,
                    directed_rows[i].want);
    settle();

    // Full range, threshold zero: need_data must stay low
    configure(16'hffff, 11'd0);
    run_mixed(150);
    settle();

    // Swap idling: the sender now idles most
    sender_idle_pct = 86;
    recv_idle_pct   = 10;
    configure(16'd1, 11'd1024);
    run_mixed(100);
    settle();

    // No idling; hold the result side off so the block backs up
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    configure(16'd0, 11'($urandom_range(0, 1024)));
    hold_off_req = 1'b1;
    run_mixed(100);
    settle();

    configure(16'($urandom_range(1, 65535)), 11'($urandom_range(0, 1024)));
    run_mixed(250);
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/pasq_pkg.sv
rtl/pwm_audio_sample_queue_core.sv
tb/sv/pwm_audio_sample_queue_core_tb.sv
